FILE: rtl/plm_pkg.sv
// Shared constants, types and threshold table for the packet level meter.
// No dependencies; every other file of the block imports this package.
package plm_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int TIME_W             = 32;
    localparam int LEVEL_W            = 8;
    localparam int INTERVAL_W         = 16;
    localparam int CFG_IDX_W          = 8;
    localparam int CFG_DATA_W         = 16;
    localparam int MEAN_W             = 16;
    localparam int DEF_MAX_PACKET_SAMPLES = 4096;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(300);
    localparam logic signed [LEVEL_W-1:0] FLOOR_DB = -LEVEL_W'(96);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_METER_ENABLE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = CFG_IDX_W'(1);

    // smallest mean reaching each dB step, -6 dB downward
    localparam int NUM_THRESH = 90;
    localparam int THR_IDX_W  = $clog2(NUM_THRESH + 1);
    localparam logic [MEAN_W-1:0] LEVEL_THRESH [NUM_THRESH] = '{
        16'd29274, 16'd26090, 16'd23253, 16'd20724, 16'd18471, 16'd16462,
        16'd14672, 16'd13076, 16'd11654, 16'd10387, 16'd9258,  16'd8251,
        16'd7354,  16'd6554,  16'd5841,  16'd5206,  16'd4640,  16'd4135,
        16'd3686,  16'd3285,  16'd2928,  16'd2609,  16'd2326,  16'd2073,
        16'd1848,  16'd1647,  16'd1468,  16'd1308,  16'd1166,  16'd1039,
        16'd926,   16'd826,   16'd736,   16'd656,   16'd585,   16'd521,
        16'd464,   16'd414,   16'd369,   16'd329,   16'd293,   16'd261,
        16'd233,   16'd208,   16'd185,   16'd165,   16'd147,   16'd131,
        16'd117,   16'd104,   16'd93,    16'd83,    16'd74,    16'd66,
        16'd59,    16'd53,    16'd47,    16'd42,    16'd37,    16'd33,
        16'd30,    16'd27,    16'd24,    16'd21,    16'd19,    16'd17,
        16'd15,    16'd14,    16'd12,    16'd11,    16'd10,    16'd9,
        16'd8,     16'd7,     16'd6,     16'd6,     16'd5,     16'd5,
        16'd4,     16'd4,     16'd3,     16'd3,     16'd3,     16'd3,
        16'd2,     16'd2,     16'd2,     16'd2,     16'd2,     16'd2
    };

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV,
        ST_LVL,
        ST_LOAD
    } plm_state_t;

    typedef struct packed {
        logic take;
        logic div_start;
        logic div_step;
        logic lvl_start;
        logic lvl_step;
        logic out_load;
    } plm_cmd_t;

    typedef struct packed {
        logic report;
        logic div_done;
        logic lvl_done;
        logic out_free;
    } plm_status_t;

endpackage

FILE: rtl/plm_if.sv
// Channel interfaces: sample input, level output and configuration write.
// Depends on plm_pkg.
interface plm_sample_if;
    import plm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       packet_end;
    logic [TIME_W-1:0]          time_ms;

    modport source (output valid, sample, packet_end, time_ms, input ready);
    modport sink   (input valid, sample, packet_end, time_ms, output ready);
endinterface

interface plm_level_if;
    import plm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] level_db;

    modport source (output valid, level_db, input ready);
    modport sink   (input valid, level_db, output ready);
endinterface

interface plm_cfg_if;
    import plm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/plm_ctrl.sv
// Sequencer for the level meter: accumulate, divide, threshold scan, load.
// Depends on plm_pkg; drives the datapath through plm_cmd_t.
module plm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 samp_valid,
    output logic                 samp_ready,
    input  plm_pkg::plm_status_t status,
    output plm_pkg::plm_cmd_t    cmd
);
    import plm_pkg::*;

    plm_state_t state_reg;
    plm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        samp_ready = 1'b0;
        unique case (state_reg)
            ST_ACC:
            begin
                samp_ready = 1'b1;
                cmd.take   = samp_valid;
                if (samp_valid && status.report)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.lvl_start = 1'b1;
                    state_next    = ST_LVL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_LVL:
            begin
                if (status.lvl_done)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    cmd.lvl_step = 1'b1;
                end
            end
            ST_LOAD:
            begin
                // wait for the output register to drain
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

endmodule

FILE: rtl/plm_datapath.sv
// Datapath: abs-sum accumulator, restoring divider, dB threshold scan,
// configuration registers and output register. Depends on plm_pkg.
module plm_datapath #(
    parameter int MAX_PACKET_SAMPLES = plm_pkg::DEF_MAX_PACKET_SAMPLES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plm_pkg::plm_cmd_t                   cmd,
    output plm_pkg::plm_status_t                status,
    input  logic signed [plm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                packet_end,
    input  logic [plm_pkg::TIME_W-1:0]          time_ms,
    input  logic                                cfg_we,
    input  logic [plm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [plm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [plm_pkg::LEVEL_W-1:0]  level_db
);
    import plm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PACKET_SAMPLES + 1);
    localparam int SUM_W  = $clog2(MAX_PACKET_SAMPLES) + SAMPLE_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_SAMPLES);

    // configuration
    logic                  enable_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [TIME_W-1:0]     last_time_reg;

    // accumulator
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_upd;
    logic [CNT_W-1:0] count_upd;
    logic [SAMPLE_W:0] mag;
    logic [TIME_W-1:0] elapsed;

    // divider
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_diff;

    // threshold scan
    logic [THR_IDX_W-1:0]      idx_reg;
    logic signed [LEVEL_W-1:0] lvl_reg;
    logic [MEAN_W-1:0]         mean;

    // output register
    logic                      out_valid_reg;
    logic signed [LEVEL_W-1:0] out_level_reg;

    // |-32768| comes out as 32768 in the 17-bit magnitude
    assign mag = sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};

    always_comb
    begin
        sum_upd   = sum_reg;
        count_upd = count_reg;
        if (count_reg < MAX_CNT)
        begin
            sum_upd   = sum_reg + SUM_W'(mag);
            count_upd = count_reg + CNT_W'(1);
        end
    end

    assign elapsed = time_ms - last_time_reg;

    assign status.report   = packet_end && enable_reg
                             && (elapsed >= TIME_W'(interval_reg));
    assign status.div_done = (dcnt_reg == '0);
    assign status.lvl_done = (idx_reg == THR_IDX_W'(NUM_THRESH));
    assign status.out_free = !out_valid_reg || out_ready;

    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign mean       = quo_reg[MEAN_W-1:0];

    // configuration and timestamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            interval_reg  <= INTERVAL_RESET;
            last_time_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_METER_ENABLE)
            begin
                enable_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == REG_REPORT_INTERVAL)
            begin
                interval_reg <= cfg_data[INTERVAL_W-1:0];
            end
            if (cmd.div_start)
            begin
                last_time_reg <= time_ms;
            end
        end
    end

    // packet accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.take)
        begin
            if (packet_end)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_upd;
                count_reg <= count_upd;
            end
        end
    end

    // restoring divider, one quotient bit per cycle; divisor is never zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= DCNT_W'(SUM_W);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= sum_upd;
            rem_reg <= '0;
            dvs_reg <= count_upd;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial_diff[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // threshold scan: one table entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= THR_IDX_W'(NUM_THRESH);
        end
        else if (cmd.lvl_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.lvl_step)
        begin
            idx_reg <= idx_reg + THR_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lvl_start)
        begin
            lvl_reg <= FLOOR_DB;
        end
        else if (cmd.lvl_step && mean >= LEVEL_THRESH[idx_reg])
        begin
            lvl_reg <= lvl_reg + LEVEL_W'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_level_reg <= lvl_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level_db  = out_level_reg;

endmodule

FILE: rtl/pcm_level_meter_db_unit.sv
// Top level of the packet level meter: controller plus datapath.
// Depends on plm_pkg, plm_if, plm_ctrl and plm_datapath.
//
//  channel  dir  payload                          transaction when
//  samp     in   sample, packet_end, time_ms      samp.valid && samp.ready
//  level    out  level_db                         level.valid && level.ready
//  cfg      in   index, data                      cfg.valid && cfg.ready
//
// Samples are taken without gaps while no report runs. A reporting packet end
// holds off input while the divider forms SUM_W = ceil(log2(max samples))+16
// quotient bits (28 by default), 90 thresholds are scanned and the level loads.
// The load waits while a previous level is still stalled in the output register.
// cfg is always ready. Reset (rst_n low, asynchronous) clears sums, counts,
// timestamp and config registers to their defaults; no clearing pass is needed.
module pcm_level_meter_db_unit #(
    parameter int MAX_PACKET_SAMPLES = plm_pkg::DEF_MAX_PACKET_SAMPLES
) (
    input logic         clk,
    input logic         rst_n,
    plm_sample_if.sink  samp,
    plm_level_if.source level,
    plm_cfg_if.sink     cfg
);
    import plm_pkg::*;

    plm_cmd_t    cmd;
    plm_status_t status;

    assign cfg.ready = 1'b1;

    plm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .samp_valid (samp.valid),
        .samp_ready (samp.ready),
        .status     (status),
        .cmd        (cmd)
    );

    plm_datapath #(
        .MAX_PACKET_SAMPLES (MAX_PACKET_SAMPLES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample     (samp.sample),
        .packet_end (samp.packet_end),
        .time_ms    (samp.time_ms),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_valid  (level.valid),
        .out_ready  (level.ready),
        .level_db   (level.level_db)
    );

endmodule

FILE: rtl/plm_checker.sv
// Port-level checks for pcm_level_meter_db_unit, attached by bind.
// Depends on plm_pkg and the top level's interface ports.
module plm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                samp_valid,
    input logic                                samp_ready,
    input logic                                samp_packet_end,
    input logic                                level_valid,
    input logic                                level_ready,
    input logic signed [plm_pkg::LEVEL_W-1:0]  level_db
);
    import plm_pkg::*;

    // a stalled level holds
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid && !level_ready |=> level_valid && $stable(level_db))
        else $error("level changed while stalled");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid |-> (level_db >= FLOOR_DB) && (level_db <= LEVEL_W'(0)))
        else $error("level out of range");

    // input stalls only after a packet-end transaction
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(samp_ready) |-> $past(samp_valid && samp_ready && samp_packet_end))
        else $error("input stalled without a packet end");

    // a new level appears together with the return to sample intake
    a_load_resume: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(level_valid) |-> $rose(samp_ready))
        else $error("level loaded outside the load step");

endmodule

bind pcm_level_meter_db_unit plm_checker u_plm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .samp_valid      (samp.valid),
    .samp_ready      (samp.ready),
    .samp_packet_end (samp.packet_end),
    .level_valid     (level.valid),
    .level_ready     (level.ready),
    .level_db        (level.level_db)
);
